/* rtl/line_pixel_sorter_unit_macros.svh */
// ----------------------------------------------------------------------------
// line_pixel_sorter_unit_macros.svh
// Assertion helpers shared by the pixel line sorter RTL.
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_SORTER_UNIT_MACROS_SVH
`define LINE_PIXEL_SORTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define LPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lps check failed");

// Next-cycle implication, disabled while reset is asserted
`define LPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lps check failed");

`endif

/* rtl/lps_pkg.sv */
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and helpers for the pixel line sorter.
// ----------------------------------------------------------------------------
package lps_pkg;

  // One RGB pixel, red in the high byte
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // Per-cell control, built by the sequencer for each cell of the chain
  typedef struct packed {
    logic load;     // take the incoming pixel
    logic shift;    // take the next cell's pixel (drain toward the head)
    logic cmp_lo;   // lower member of a compare pair this cycle
    logic cmp_hi;   // upper member of a compare pair this cycle
    logic key_sel;  // 0: red key, 1: green key
  } cell_ctrl_t;

  // Sort key of a pixel
  function automatic logic [7:0] key_of(pix_t p, logic sel);
    key_of = sel ? p.green : p.red;
  endfunction

endpackage

/* rtl/lps_pix_if.sv */
// ----------------------------------------------------------------------------
// lps_pix_if
// Valid/ready channel carrying one incoming pixel and its line end mark.
// ----------------------------------------------------------------------------
interface lps_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pix_red;
  logic [7:0] pix_green;
  logic [7:0] pix_blue;
  logic       line_end;

  modport source (output valid, pix_red, pix_green, pix_blue, line_end, input ready);
  modport sink   (input valid, pix_red, pix_green, pix_blue, line_end, output ready);
endinterface

/* rtl/lps_res_if.sv */
// ----------------------------------------------------------------------------
// lps_res_if
// Valid/ready channel carrying one sorted pixel with its line flags.
// ----------------------------------------------------------------------------
interface lps_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       out_last;
  logic       overflow;

  modport source (output valid, out_red, out_green, out_blue, out_last, overflow,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_last, overflow,
                  output ready);
endinterface

/* rtl/lps_cfg_if.sv */
// ----------------------------------------------------------------------------
// lps_cfg_if
// Valid/ready write channel for the sort key register.
// ----------------------------------------------------------------------------
interface lps_cfg_if;
  logic valid;
  logic ready;
  logic key_channel;

  modport source (output valid, key_channel, input ready);
  modport sink   (input valid, key_channel, output ready);
endinterface

/* rtl/lps_cell.sv */
// ----------------------------------------------------------------------------
// lps_cell
// One slot of the sorting chain: holds a pixel, loads, drains, and does its
// half of an odd-even compare-exchange with a neighbor.
// ----------------------------------------------------------------------------
module lps_cell (
  input  logic               clk_i,
  input  lps_pkg::cell_ctrl_t ctrl_i,
  input  lps_pkg::pix_t      in_pix_i,
  input  lps_pkg::pix_t      prev_pix_i,
  input  lps_pkg::pix_t      next_pix_i,
  output lps_pkg::pix_t      pix_o
);

  lps_pkg::pix_t pix_q;
  lps_pkg::pix_t pix_d;
  logic          swap_lo;
  logic          swap_hi;

  // Swap only on a strictly greater key so equal keys keep arrival order
  assign swap_lo = ctrl_i.cmp_lo &&
                   (lps_pkg::key_of(pix_q, ctrl_i.key_sel) >
                    lps_pkg::key_of(next_pix_i, ctrl_i.key_sel));
  assign swap_hi = ctrl_i.cmp_hi &&
                   (lps_pkg::key_of(prev_pix_i, ctrl_i.key_sel) >
                    lps_pkg::key_of(pix_q, ctrl_i.key_sel));

  // Pick the next content of the slot
  always_comb begin
    pix_d = pix_q;
    priority if (ctrl_i.load) begin
      pix_d = in_pix_i;
    end else if (ctrl_i.shift || swap_lo) begin
      pix_d = next_pix_i;
    end else if (swap_hi) begin
      pix_d = prev_pix_i;
    end else begin
      pix_d = pix_q;
    end
  end

  // Hold the pixel
  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign pix_o = pix_q;

endmodule

/* rtl/line_pixel_sorter_unit.sv */
// ----------------------------------------------------------------------------
// line_pixel_sorter_unit
// Sorts one line of RGB pixels by the red or green key in a chain of cells.
// ----------------------------------------------------------------------------
// Input: one pixel per cycle while a line is collected (ready stays high).
// After the line end pixel is taken, odd-even compare-exchange runs across
// the cell chain, then one sorted pixel per cycle drains from the head cell
// while the result receiver is ready.
// Reset clears the fill count, drop flag, key register and sequencer state.
// ----------------------------------------------------------------------------
`include "line_pixel_sorter_unit_macros.svh"

module line_pixel_sorter_unit #(
  parameter int unsigned MAX_LINE = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  lps_pix_if.sink   pix_i,
  lps_res_if.source res_o,
  lps_cfg_if.sink   cfg_i
);

  localparam int unsigned CntW  = $clog2(MAX_LINE + 1);
  localparam int unsigned SortW = $clog2(MAX_LINE);

  typedef enum logic [1:0] {
    ST_FILL,
    ST_SORT,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q;
  logic [SortW-1:0]  sort_cnt_q;
  logic              dropped_q;
  logic              key_cfg_q;
  logic              key_q;

  logic              in_acc;
  logic              out_acc;
  logic              full;
  logic              sort_act;
  lps_pkg::pix_t     in_pix;
  lps_pkg::pix_t     cell_pix [MAX_LINE];

  assign in_pix   = '{red: pix_i.pix_red, green: pix_i.pix_green, blue: pix_i.pix_blue};
  assign full     = (count_q == CntW'(MAX_LINE));
  assign in_acc   = pix_i.valid && pix_i.ready;
  assign out_acc  = res_o.valid && res_o.ready;
  assign sort_act = (state_q == ST_SORT);

  // Handshakes
  assign pix_i.ready = (state_q == ST_FILL);
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = (state_q == ST_EMIT);

  // Drive results from the head cell
  assign res_o.out_red   = cell_pix[0].red;
  assign res_o.out_green = cell_pix[0].green;
  assign res_o.out_blue  = cell_pix[0].blue;
  assign res_o.out_last  = (count_q == CntW'(1));
  assign res_o.overflow  = dropped_q;

  // Capture the key register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_cfg_q <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      key_cfg_q <= cfg_i.key_channel;
    end
  end

  // Sequence fill, sort and drain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      count_q    <= '0;
      sort_cnt_q <= '0;
      dropped_q  <= 1'b0;
      key_q      <= 1'b0;
    end else begin
      unique case (state_q)
        ST_FILL: begin
          if (in_acc) begin
            if (full) begin
              dropped_q <= 1'b1;
            end else begin
              count_q <= count_q + CntW'(1);
            end
            if (pix_i.line_end) begin
              key_q      <= key_cfg_q;
              sort_cnt_q <= '0;
              state_q    <= ST_SORT;
            end
          end
        end
        ST_SORT: begin
          sort_cnt_q <= sort_cnt_q + SortW'(1);
          if (sort_cnt_q == SortW'(MAX_LINE - 1)) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            count_q <= count_q - CntW'(1);
            if (count_q == CntW'(1)) begin
              dropped_q <= 1'b0;
              state_q   <= ST_FILL;
            end
          end
        end
        default: begin
          state_q <= ST_FILL;
        end
      endcase
    end
  end

  // Build the cell chain
  for (genvar i = 0; i < MAX_LINE; i++) begin : g_cell
    lps_pkg::cell_ctrl_t ctrl;
    lps_pkg::pix_t       prev_pix;
    lps_pkg::pix_t       next_pix;

    // Tie off missing neighbors at the ends; their compare enables stay low
    if (i == 0) begin : g_head
      assign prev_pix = cell_pix[i];
    end else begin : g_body_prev
      assign prev_pix = cell_pix[i-1];
    end
    if (i == MAX_LINE - 1) begin : g_tail
      assign next_pix = cell_pix[i];
    end else begin : g_body_next
      assign next_pix = cell_pix[i+1];
    end

    assign ctrl.load    = in_acc && (count_q == CntW'(i));
    assign ctrl.shift   = out_acc;
    assign ctrl.key_sel = key_q;
    // Even phase pairs (0,1),(2,3)...; odd phase pairs (1,2),(3,4)...
    assign ctrl.cmp_lo  = sort_act && (sort_cnt_q[0] == 1'(i % 2)) &&
                          (CntW'(i + 1) < count_q);
    if (i == 0) begin : g_no_hi
      assign ctrl.cmp_hi = 1'b0;
    end else begin : g_hi
      assign ctrl.cmp_hi = sort_act && (sort_cnt_q[0] != 1'(i % 2)) &&
                           (CntW'(i) < count_q);
    end

    lps_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .in_pix_i   (in_pix),
      .prev_pix_i (prev_pix),
      .next_pix_i (next_pix),
      .pix_o      (cell_pix[i])
    );
  end

  // Results never overlap collection of a line
  `LPS_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, res_o.valid, !pix_i.ready)
  // A draining line always holds at least one pixel
  `LPS_ASSERT_IMP(a_emit_nonempty, clk_i, rst_ni, state_q == ST_EMIT, count_q != '0)
  // Taking the line end pixel starts the sort
  `LPS_ASSERT_NXT(a_end_sorts, clk_i, rst_ni, in_acc && pix_i.line_end, state_q == ST_SORT)
  // Handing off the last result reopens the input with an empty line
  `LPS_ASSERT_NXT(a_last_reopens, clk_i, rst_ni, out_acc && res_o.out_last,
                  pix_i.ready && (count_q == '0) && !dropped_q)

endmodule
